FILE: rtl/assert_macros.svh
// Assertion macros shared by the steering pipeline modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LFPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lfps: assertion failed");

// Checked on every edge, reset included.
`define LFPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lfps: assertion failed");

`endif

FILE: rtl/lfps_pkg.sv
`timescale 1ns / 1ps
// Package for the line follower PD steering block: types, codes, constants.
// No dependencies.
package lfps_pkg;

  typedef enum logic [1:0] {
    ModeBrake = 2'd0,
    ModeFwd   = 2'd1,
    ModeRev   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CfgBaseSpeed = 3'd0,
    CfgMinSpeed  = 3'd1,
    CfgDropRate  = 3'd2,
    CfgPropGain  = 3'd3,
    CfgDerivGain = 3'd4,
    CfgSearchFwd = 3'd5,
    CfgSearchRev = 3'd6
  } cfg_idx_e;

  localparam int unsigned DutyMaxDef = 1000;

  // register reset values
  localparam logic [9:0] BaseSpeedRst = 10'd450;
  localparam logic [9:0] MinSpeedRst  = 10'd90;
  localparam logic [7:0] DropRateRst  = 8'd50;
  localparam logic [7:0] PropGainRst  = 8'd42;
  localparam logic [7:0] DerivGainRst = 8'd75;
  localparam logic [9:0] SearchFwdRst = 10'd350;
  localparam logic [9:0] SearchRevRst = 10'd260;

  // sensor patterns
  localparam logic [3:0] SensLost = 4'b0000;

  // error magnitudes in tenths
  localparam logic [5:0] ErrSmall = 6'd10;
  localparam logic [5:0] ErrMid   = 6'd25;
  localparam logic [5:0] ErrBig   = 6'd42;

  localparam logic [5:0] SharpThr = 6'd40;
  localparam logic [5:0] MedThr   = 6'd20;

  localparam logic signed [13:0] SharpOuter = 14'sd380;
  localparam logic signed [13:0] SharpInner = -14'sd180;
  localparam logic signed [13:0] MedAdd     = 14'sd120;
  localparam logic signed [13:0] MedInner   = -14'sd90;

  // x / 10 == (x * 52429) >> 19, exact for x below 81920
  localparam logic [31:0] Recip10      = 32'd52429;
  localparam int unsigned Recip10Shift = 19;

  typedef struct packed {
    logic signed [6:0] err;
    logic signed [7:0] dlt;        // err - previous err
    logic [5:0]        abs_err;
    logic              lost;
    logic              spin_right;
  } s1_t;

  typedef struct packed {
    logic [13:0]        slow_prod;  // |err| * drop_rate
    logic signed [15:0] pd_sum;     // kp*err + kd*dlt
    logic               err_pos;
    logic               sharp;
    logic               med;
    logic               lost;
    logic               spin_right;
  } s2_t;

  typedef struct packed {
    logic [10:0]        slowdown;
    logic signed [12:0] pd;
    logic               err_pos;
    logic               sharp;
    logic               med;
    logic               lost;
    logic               spin_right;
  } s3_t;

  typedef struct packed {
    mode_e      mode;
    logic [9:0] duty;
  } wheel_t;

  typedef struct packed {
    logic signed [6:0] err;
    logic              side_set;
    logic              side_right;
  } err_map_t;

  function automatic err_map_t map_sensors(input logic [3:0] s);
    err_map_t m;
    m.err        = 7'sd0;
    m.side_set   = 1'b0;
    m.side_right = 1'b0;
    case (s)
      4'h2: begin
        m.err = $signed({1'b0, ErrSmall}); m.side_set = 1'b1; m.side_right = 1'b1;
      end
      4'h3: begin
        m.err = $signed({1'b0, ErrMid}); m.side_set = 1'b1; m.side_right = 1'b1;
      end
      4'h1, 4'h7: begin
        m.err = $signed({1'b0, ErrBig}); m.side_set = 1'b1; m.side_right = 1'b1;
      end
      4'h4:       begin m.err = -$signed({1'b0, ErrSmall}); m.side_set = 1'b1; end
      4'hC:       begin m.err = -$signed({1'b0, ErrMid});   m.side_set = 1'b1; end
      4'h8, 4'hE: begin m.err = -$signed({1'b0, ErrBig});   m.side_set = 1'b1; end
      default:    ;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/lfps_decode.sv
`timescale 1ns / 1ps
// Input stage: sensor pattern to error, derivative and side memory.
// Depends on lfps_pkg, assert_macros.svh.
`include "assert_macros.svh"
module lfps_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [3:0]    sensor_bits_i,
  output logic          valid_o,
  input  logic          ready_i,
  output lfps_pkg::s1_t s1_o
);
  import lfps_pkg::*;

  logic              vld_q;
  s1_t               s1_q, s1_d;
  logic signed [6:0] prev_err_q, prev_err_d;
  logic              side_q, side_d;
  err_map_t          m;
  logic              lost;
  logic              accept;

  assign ready_o = !vld_q || ready_i;
  assign accept  = valid_i && ready_o;
  assign m       = map_sensors(sensor_bits_i);
  assign lost    = (sensor_bits_i == SensLost);

  always_comb begin
    s1_d.err        = m.err;
    s1_d.dlt        = 8'(m.err) - 8'(prev_err_q);
    s1_d.abs_err    = m.err[6] ? 6'(-m.err) : 6'(m.err);
    s1_d.lost       = lost;
    s1_d.spin_right = side_q;
    prev_err_d      = prev_err_q;
    side_d          = side_q;
    if (accept && !lost) begin
      prev_err_d = m.err;
      if (m.side_set) begin
        side_d = m.side_right;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      prev_err_q <= 7'sd0;
      side_q     <= 1'b0;
    end else begin
      prev_err_q <= prev_err_d;
      side_q     <= side_d;
      if (ready_o) begin
        vld_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = vld_q;
  assign s1_o    = s1_q;

  // a lost line leaves the derivative history alone
  `LFPS_ASSERT(a_lost_keeps_err, accept && lost |=> $stable(prev_err_q) && $stable(side_q))
  `LFPS_ASSERT(a_held_stage, vld_q && !ready_i |=> vld_q && $stable(s1_q))

endmodule

FILE: rtl/lfps_mult.sv
`timescale 1ns / 1ps
// Product stage: slowdown product and PD gain sum.
// Depends on lfps_pkg.
module lfps_mult (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  lfps_pkg::s1_t s1_i,
  input  logic [7:0]    drop_rate_i,
  input  logic [7:0]    prop_gain_i,
  input  logic [7:0]    deriv_gain_i,
  output logic          valid_o,
  input  logic          ready_i,
  output lfps_pkg::s2_t s2_o
);
  import lfps_pkg::*;

  logic               vld_q;
  s2_t                s2_q, s2_d;
  logic signed [15:0] p_term, d_term;

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    p_term         = $signed({8'b0, prop_gain_i}) * 16'(s1_i.err);
    d_term         = $signed({8'b0, deriv_gain_i}) * 16'(s1_i.dlt);
    s2_d.slow_prod = 14'({8'b0, s1_i.abs_err} * {6'b0, drop_rate_i});
    s2_d.pd_sum    = p_term + d_term;
    s2_d.err_pos   = (s1_i.err > 7'sd0);
    s2_d.sharp     = (s1_i.abs_err >= SharpThr);
    s2_d.med       = (s1_i.abs_err >= MedThr);
    s2_d.lost      = s1_i.lost;
    s2_d.spin_right = s1_i.spin_right;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = vld_q;
  assign s2_o    = s2_q;

endmodule

FILE: rtl/lfps_div.sv
`timescale 1ns / 1ps
// Divide-by-ten stage: reciprocal multiply, PD quotient truncated toward zero.
// Depends on lfps_pkg.
module lfps_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  lfps_pkg::s2_t s2_i,
  output logic          valid_o,
  input  logic          ready_i,
  output lfps_pkg::s3_t s3_o
);
  import lfps_pkg::*;

  logic        vld_q;
  s3_t         s3_q, s3_d;
  logic [14:0] pd_mag;
  logic [31:0] slow_prod32, pd_prod32;
  logic [11:0] pd_quot;

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    pd_mag      = s2_i.pd_sum[15] ? 15'(-s2_i.pd_sum) : 15'(s2_i.pd_sum);
    slow_prod32 = 32'(s2_i.slow_prod) * Recip10;
    pd_prod32   = 32'(pd_mag) * Recip10;
    pd_quot     = 12'(pd_prod32 >> Recip10Shift);
    s3_d.slowdown   = 11'(slow_prod32 >> Recip10Shift);
    // magnitude divide then restore sign: truncates toward zero
    s3_d.pd         = s2_i.pd_sum[15] ? -$signed({1'b0, pd_quot}) : $signed({1'b0, pd_quot});
    s3_d.err_pos    = s2_i.err_pos;
    s3_d.sharp      = s2_i.sharp;
    s3_d.med        = s2_i.med;
    s3_d.lost       = s2_i.lost;
    s3_d.spin_right = s2_i.spin_right;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s3_q <= s3_d;
    end
  end

  assign valid_o = vld_q;
  assign s3_o    = s3_q;

endmodule

FILE: rtl/lfps_drive.sv
`timescale 1ns / 1ps
// Output stage: base clamp, steering select, wheel mode and saturated duty.
// Depends on lfps_pkg, assert_macros.svh.
`include "assert_macros.svh"
module lfps_drive #(
  parameter int unsigned DutyMax = lfps_pkg::DutyMaxDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  lfps_pkg::s3_t    s3_i,
  input  logic [9:0]       base_speed_i,
  input  logic [9:0]       min_speed_i,
  input  logic [9:0]       search_fwd_i,
  input  logic [9:0]       search_rev_i,
  output logic             valid_o,
  input  logic             ready_i,
  output lfps_pkg::wheel_t left_o,
  output lfps_pkg::wheel_t right_o,
  output logic             line_lost_o
);
  import lfps_pkg::*;

  logic               vld_q;
  wheel_t             left_q, right_q;
  logic               lost_q;
  logic signed [11:0] base_raw, base_c;
  logic signed [13:0] left_v, right_v, fwd_v, rev_v, base_med;

  function automatic wheel_t drive_f(input logic signed [13:0] v);
    wheel_t      w;
    logic [12:0] mag;
    mag = v[13] ? 13'(-v) : 13'(v);
    if (v == 14'sd0) begin
      w.mode = ModeBrake;
    end else if (v[13]) begin
      w.mode = ModeRev;
    end else begin
      w.mode = ModeFwd;
    end
    w.duty = (32'(mag) > DutyMax) ? 10'(DutyMax) : mag[9:0];
    return w;
  endfunction

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    base_raw = $signed({2'b0, base_speed_i}) - $signed({1'b0, s3_i.slowdown});
    base_c   = (base_raw < $signed({2'b0, min_speed_i})) ? $signed({2'b0, min_speed_i})
                                                         : base_raw;
    fwd_v    = $signed({4'b0, search_fwd_i});
    rev_v    = -$signed({4'b0, search_rev_i});
    base_med = 14'(base_c) + MedAdd;
    if (s3_i.lost) begin
      left_v  = s3_i.spin_right ? fwd_v : rev_v;
      right_v = s3_i.spin_right ? rev_v : fwd_v;
    end else if (s3_i.sharp) begin
      left_v  = s3_i.err_pos ? SharpOuter : SharpInner;
      right_v = s3_i.err_pos ? SharpInner : SharpOuter;
    end else if (s3_i.med) begin
      left_v  = s3_i.err_pos ? base_med : MedInner;
      right_v = s3_i.err_pos ? MedInner : base_med;
    end else begin
      left_v  = 14'(base_c) + 14'(s3_i.pd);
      right_v = 14'(base_c) - 14'(s3_i.pd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      left_q  <= drive_f(left_v);
      right_q <= drive_f(right_v);
      lost_q  <= s3_i.lost;
    end
  end

  assign valid_o     = vld_q;
  assign left_o      = left_q;
  assign right_o     = right_q;
  assign line_lost_o = lost_q;

  `LFPS_ASSERT(a_brake_left_zero, vld_q && left_q.mode == ModeBrake |-> left_q.duty == 10'd0)
  `LFPS_ASSERT(a_brake_right_zero, vld_q && right_q.mode == ModeBrake |-> right_q.duty == 10'd0)

endmodule

FILE: rtl/line_follow_pd_steering.sv
`timescale 1ns / 1ps
// Line follower PD steering, top level. Four-stage pipeline: decode, products,
// divide by ten, steering select and output register. Each stage registers its
// result in turn. Throughput: one beat per cycle while out_ready_i is high; the
// output register stalls upstream stages only as they fill. Reset (async, low)
// empties the pipeline, clears error and side memory, loads register defaults.
`include "assert_macros.svh"
module line_follow_pd_steering #(
  parameter int unsigned DutyMax = lfps_pkg::DutyMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] sensor_bits_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] left_mode_o,
  output logic [9:0] left_duty_o,
  output logic [1:0] right_mode_o,
  output logic [9:0] right_duty_o,
  output logic       line_lost_o
);
  import lfps_pkg::*;

  logic [9:0] base_speed_q, min_speed_q, search_fwd_q, search_rev_q;
  logic [7:0] drop_rate_q, prop_gain_q, deriv_gain_q;

  logic   v1, r1, v2, r2, v3, r3;
  s1_t    s1;
  s2_t    s2;
  s3_t    s3;
  wheel_t left_w, right_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q <= BaseSpeedRst;
      min_speed_q  <= MinSpeedRst;
      drop_rate_q  <= DropRateRst;
      prop_gain_q  <= PropGainRst;
      deriv_gain_q <= DerivGainRst;
      search_fwd_q <= SearchFwdRst;
      search_rev_q <= SearchRevRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBaseSpeed: base_speed_q <= cfg_data_i;
        CfgMinSpeed:  min_speed_q  <= cfg_data_i;
        CfgDropRate:  drop_rate_q  <= cfg_data_i[7:0];
        CfgPropGain:  prop_gain_q  <= cfg_data_i[7:0];
        CfgDerivGain: deriv_gain_q <= cfg_data_i[7:0];
        CfgSearchFwd: search_fwd_q <= cfg_data_i;
        CfgSearchRev: search_rev_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  lfps_decode u_decode (
    .clk_i,
    .rst_ni,
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .sensor_bits_i (sensor_bits_i),
    .valid_o       (v1),
    .ready_i       (r1),
    .s1_o          (s1)
  );

  lfps_mult u_mult (
    .clk_i,
    .rst_ni,
    .valid_i      (v1),
    .ready_o      (r1),
    .s1_i         (s1),
    .drop_rate_i  (drop_rate_q),
    .prop_gain_i  (prop_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .valid_o      (v2),
    .ready_i      (r2),
    .s2_o         (s2)
  );

  lfps_div u_div (
    .clk_i,
    .rst_ni,
    .valid_i (v2),
    .ready_o (r2),
    .s2_i    (s2),
    .valid_o (v3),
    .ready_i (r3),
    .s3_o    (s3)
  );

  lfps_drive #(
    .DutyMax (DutyMax)
  ) u_drive (
    .clk_i,
    .rst_ni,
    .valid_i      (v3),
    .ready_o      (r3),
    .s3_i         (s3),
    .base_speed_i (base_speed_q),
    .min_speed_i  (min_speed_q),
    .search_fwd_i (search_fwd_q),
    .search_rev_i (search_rev_q),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .left_o       (left_w),
    .right_o      (right_w),
    .line_lost_o  (line_lost_o)
  );

  assign left_mode_o  = left_w.mode;
  assign left_duty_o  = left_w.duty;
  assign right_mode_o = right_w.mode;
  assign right_duty_o = right_w.duty;

  // empty output stage never blocks the input
  `LFPS_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o)
  // search spin always turns the wheels against each other or brakes one or both
  `LFPS_ASSERT(a_spin_not_fwd, out_valid_o && line_lost_o |-> !(left_mode_o == ModeFwd && right_mode_o == ModeFwd))
  `LFPS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule

FILE: tb/sv/line_follow_pd_steering_test.sv
`timescale 1ns / 1ps
// Testbench for line_follow_pd_steering: random and directed sensor beats, register
// phases, random gaps and stalls; expected wheel commands come from an in-bench predictor.
// Depends on lfps_pkg and the line_follow_pd_steering RTL only.
module line_follow_pd_steering_test;
  import lfps_pkg::*;

  localparam int DutyMax     = DutyMaxDef;
  localparam int HoldCycles  = 200;
  localparam int StallLimit  = 2000;
  localparam int PhaseItems  = 240;
  localparam int NumPhases   = 8;
  localparam int PrintCap    = 40;

  typedef struct packed {
    wheel_t left;
    wheel_t right;
    logic   lost;
  } steer_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [9:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [3:0] sensor_bits_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] left_mode_o;
  logic [9:0] left_duty_o;
  logic [1:0] right_mode_o;
  logic [9:0] right_duty_o;
  logic       line_lost_o;

  line_follow_pd_steering #(
    .DutyMax(DutyMax)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sensor_bits_i(sensor_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .left_mode_o  (left_mode_o),
    .left_duty_o  (left_duty_o),
    .right_mode_o (right_mode_o),
    .right_duty_o (right_duty_o),
    .line_lost_o  (line_lost_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor copy of the registers and the tracking state
  int base_spd  = BaseSpeedRst;
  int min_spd   = MinSpeedRst;
  int drop      = DropRateRst;
  int kp        = PropGainRst;
  int kd        = DerivGainRst;
  int srch_fwd  = SearchFwdRst;
  int srch_rev  = SearchRevRst;
  int prev_err  = 0;
  logic spin_right = 1'b0;

  logic [3:0] sens_q [$];
  steer_t     want_cmd_q [$];
  int         fail_cnt = 0;
  int         res_cnt = 0;

  logic sens_took = 1'b0;
  logic in_gap_on = 1'b1;
  logic out_stall_on = 1'b1;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_req = 0;
  int   hold_ack = 0;

  function automatic wheel_t wheel_of(input int v);
    wheel_t w;
    int mag;
    if (v > 0) begin
      w.mode = ModeFwd;
      mag = v;
    end else if (v < 0) begin
      w.mode = ModeRev;
      mag = -v;
    end else begin
      w.mode = ModeBrake;
      mag = 0;
    end
    if (mag > DutyMax) mag = DutyMax;
    w.duty = mag[9:0];
    return w;
  endfunction

  // one control tick; updates error and side memory
  function automatic steer_t steer_predict(input logic [3:0] s);
    steer_t r;
    int err;
    int mag_e;
    int base;
    int pd;
    int lw;
    int rw;
    logic side_hit;
    logic side_r;
    err = 0;
    side_hit = 1'b0;
    side_r = 1'b0;
    if (s == SensLost) begin
      if (spin_right) begin
        lw = srch_fwd;
        rw = -srch_rev;
      end else begin
        lw = -srch_rev;
        rw = srch_fwd;
      end
      r.left = wheel_of(lw);
      r.right = wheel_of(rw);
      r.lost = 1'b1;
      return r;
    end
    case (s)
      4'b0010: begin err = 10;  side_hit = 1'b1; side_r = 1'b1; end
      4'b0011: begin err = 25;  side_hit = 1'b1; side_r = 1'b1; end
      4'b0001,
      4'b0111: begin err = 42;  side_hit = 1'b1; side_r = 1'b1; end
      4'b0100: begin err = -10; side_hit = 1'b1; end
      4'b1100: begin err = -25; side_hit = 1'b1; end
      4'b1000,
      4'b1110: begin err = -42; side_hit = 1'b1; end
      default: err = 0;
    endcase
    if (side_hit) spin_right = side_r;
    mag_e = (err < 0) ? -err : err;
    base = base_spd - (mag_e * drop) / 10;
    if (base < min_spd) base = min_spd;
    pd = (kp * err + kd * (err - prev_err)) / 10;
    prev_err = err;
    if (mag_e >= 40) begin
      lw = (err > 0) ? 380 : -180;
      rw = (err > 0) ? -180 : 380;
    end else if (mag_e >= 20) begin
      lw = (err > 0) ? base + 120 : -90;
      rw = (err > 0) ? -90 : base + 120;
    end else begin
      lw = base + pd;
      rw = base - pd;
    end
    r.left = wheel_of(lw);
    r.right = wheel_of(rw);
    r.lost = 1'b0;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // mostly patterns seen while tracking a line, some lost, some arbitrary
  function automatic logic [3:0] pick_sensor();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 85) return 4'($urandom_range(0, 15));
    if (r >= 70) return SensLost;
    case ($urandom_range(0, 8))
      0: return 4'b0110;
      1: return 4'b0010;
      2: return 4'b0011;
      3: return 4'b0001;
      4: return 4'b0111;
      5: return 4'b0100;
      6: return 4'b1100;
      7: return 4'b1000;
      default: return 4'b1110;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_cnt++;
    if (fail_cnt <= PrintCap)
      $display("mismatch on %s at result beat %0d: got %0d, want %0d", what, res_cnt, got, want);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [9:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgBaseSpeed: base_spd = val;
      CfgMinSpeed:  min_spd = val;
      CfgDropRate:  drop = val[7:0];
      CfgPropGain:  kp = val[7:0];
      CfgDerivGain: kd = val[7:0];
      CfgSearchFwd: srch_fwd = val;
      CfgSearchRev: srch_rev = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (sens_q.size() != 0 || in_valid_i || want_cmd_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !sens_took) begin
        // beat still pending, hold it
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sens_q.size() != 0) begin
        sensor_bits_i <= sens_q.pop_front();
        in_valid_i <= 1'b1;
        gap_left <= in_gap_on ? pick_gap() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver; a hold request makes it refuse beats for a long stretch
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      stall_left <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (out_stall_on && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: check result beats, then predict for accepted sensor beats
  always @(posedge clk_i) begin : mon
    steer_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (want_cmd_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = want_cmd_q.pop_front();
          if (left_mode_o !== want.left.mode)
            report_mismatch("left_mode", left_mode_o, want.left.mode);
          if (left_duty_o !== want.left.duty)
            report_mismatch("left_duty", left_duty_o, want.left.duty);
          if (right_mode_o !== want.right.mode)
            report_mismatch("right_mode", right_mode_o, want.right.mode);
          if (right_duty_o !== want.right.duty)
            report_mismatch("right_duty", right_duty_o, want.right.duty);
          if (line_lost_o !== want.lost)
            report_mismatch("line_lost", line_lost_o, want.lost);
        end
        res_cnt++;
      end
      if (in_valid_i && in_ready_o) want_cmd_q.push_back(steer_predict(sensor_bits_i));
    end
    sens_took <= rst_ni && in_valid_i && in_ready_o;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("line_follow_pd_steering_test: errors");
    $finish;
  end

  initial begin : main_seq
    logic [9:0] cfg_val [7];
    int ph;
    int i;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: every pattern, side memory both ways, large error swings
    sens_q = '{4'b0000, 4'b0010, 4'b0000, 4'b0111, 4'b0100, 4'b0001, 4'b1000, 4'b0010,
               4'b1110, 4'b0011, 4'b1100, 4'b0110, 4'b1111, 4'b0000, 4'b0101, 4'b1001,
               4'b1010, 4'b1011, 4'b1101, 4'b0011, 4'b1111, 4'b0000};
    wait_drained();

    for (ph = 0; ph < NumPhases; ph++) begin
      for (i = 0; i < 7; i++) cfg_val[i] = 10'($urandom_range(0, 1023));
      case (ph)
        0: for (i = 0; i < 7; i++) cfg_val[i] = '0;
        1: for (i = 0; i < 7; i++) cfg_val[i] = '1;
        2: cfg_val = '{10'd1000, 10'd0, 10'd255, 10'd255, 10'd255, 10'd1000, 10'd1000};
        3: begin
          // clamp raises the slowed base above cruise
          cfg_val[CfgBaseSpeed] = 10'd100;
          cfg_val[CfgMinSpeed] = 10'd600;
        end
        default: ;
      endcase
      for (i = 0; i < 7; i++) cfg_write(cfg_idx_e'(i), cfg_val[i]);
      in_gap_on = (ph % 3 != 0);
      out_stall_on = (ph % 3 != 0);
      if (ph == 3) hold_req++;
      for (i = 0; i < PhaseItems; i++) sens_q.push_back(pick_sensor());
      wait_drained();
    end

    if (want_cmd_q.size() != 0) report_mismatch("results outstanding", 0, want_cmd_q.size());
    if (fail_cnt == 0) begin
      $display("line_follow_pd_steering_test: clean");
    end else begin
      $display("line_follow_pd_steering_test: errors");
    end
    $finish;
  end

endmodule
